>>> hw/rtl/cts_pkg.sv
package cts_pkg;

	localparam int MaxThreads = 16;
	localparam int IdxW = $clog2(MaxThreads);
	localparam int CntW = IdxW + 1;
	localparam int StW = 8;

	localparam logic [StW-1:0] ST_STOPPED = 8'hff;
	localparam logic [StW-1:0] ST_READY = 8'hfe;

	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_YIELD = 3'd1;
	localparam logic [2:0] CMD_SET = 3'd2;
	localparam logic [2:0] CMD_WAKE = 3'd3;
	localparam logic [2:0] CMD_EXIT = 3'd4;
	localparam logic [2:0] CMD_YIELD_TO = 3'd5;
	localparam logic [2:0] CMD_PEEK = 3'd6;
	localparam logic [2:0] CMD_STATUS = 3'd7;

	localparam logic [1:0] ADDR_THREAD_COUNT = 2'd0;

	typedef struct packed {
		logic en;
		logic we;
		logic [IdxW-1:0] addr;
		logic [StW-1:0] wdata;
	} mem_req_t;

	// thread count in use: zero becomes one, large values clamp
	function automatic logic [CntW-1:0] eff_count(input logic [4:0] tc);
		logic [CntW-1:0] c;
		if (tc == 5'd0) begin
			c = CntW'(1);
		end else if (tc > 5'(MaxThreads)) begin
			c = CntW'(MaxThreads);
		end else begin
			c = CntW'(tc);
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/cts_mem.sv
module cts_mem (
	input  logic clk,
	input  cts_pkg::mem_req_t req,
	output logic [cts_pkg::StW-1:0] rdata
);
	import cts_pkg::*;

	logic [StW-1:0] mem [MaxThreads];

	always_ff @(posedge clk) begin
		if (req.en && req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.en && !req.we) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

>>> hw/rtl/cts_unit.sv
module cts_unit (
	input  logic [cts_pkg::CntW-1:0] a,
	input  logic inc,
	input  logic [cts_pkg::CntW-1:0] n,
	output logic [cts_pkg::CntW-1:0] res,
	output logic ge
);
	import cts_pkg::*;

	logic [CntW-1:0] sum;

	// add then wrap by one subtraction of the count
	always_comb begin
		sum = a + CntW'(inc);
		ge = (sum >= n);
		res = ge ? (sum - n) : sum;
	end

endmodule

>>> hw/rtl/cooperative_thread_scheduler.sv
// Round robin cooperative thread scheduler. The thread table sits in a
// single-port memory that is touched at most once per cycle, and one shared
// add and wrap unit steps the yield, peek, exit and wake walks over it: start
// sweeps all 16 entries, a yield, peek or exit reduces the start index and
// then reads and checks each entry inspected, a wake reads and checks each
// thread in use, and every command ends with a read of the addressed entry.
// The input is not ready while an item is in work; the result is held in an
// output register, so the next item is taken while a result still waits.
module cooperative_thread_scheduler (
	input  logic clk,
	input  logic arst_n,
	// slave side
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,  // thread_id[3:0], status_value[11:4], request_id[19:12],
	                              // only_ready[20]
	input  logic [2:0] s_tuser,   // cmd[2:0]
	// master side
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,  // done_flag[0], threaded[1], current_out[5:2],
	                              // next_found[6], next_thread[10:7], status_out[18:11]
	// configuration
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cts_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SWEEP = 4'd1;
	localparam logic [3:0] S_MOD = 4'd2;
	localparam logic [3:0] S_SRD = 4'd3;
	localparam logic [3:0] S_SCHK = 4'd4;
	localparam logic [3:0] S_SEND = 4'd5;
	localparam logic [3:0] S_SETW = 4'd6;
	localparam logic [3:0] S_WRD = 4'd7;
	localparam logic [3:0] S_WCHK = 4'd8;
	localparam logic [3:0] S_STRD = 4'd9;
	localparam logic [3:0] S_STLAT = 4'd10;

	logic [3:0] state_q;
	logic [4:0] tcount_q;
	logic [CntW-1:0] n;

	logic [2:0] cmd_q;
	logic [IdxW-1:0] id_q;
	logic [StW-1:0] sval_q;
	logic [StW-1:0] req_q;
	logic only_q;

	logic running_q;
	logic [IdxW-1:0] cur_q;
	logic [CntW-1:0] t_q;
	logic [IdxW-1:0] steps_q;
	logic rdy_q;
	logic blk_q;
	logic [IdxW-1:0] pick_q;
	logic done_q;
	logic found_q;
	logic [IdxW-1:0] cand_q;

	logic m_tvalid_q;
	logic [18:0] out_q;

	mem_req_t mreq;
	logic [StW-1:0] rd;

	logic [CntW-1:0] u_a;
	logic u_inc;
	logic [CntW-1:0] u_res;
	logic u_ge;

	logic accept;
	logic id_ok;
	logic have;
	logic [StW-1:0] status;

	cts_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rd)
	);

	cts_unit u_unit (
		.a   (u_a),
		.inc (u_inc),
		.n   (n),
		.res (u_res),
		.ge  (u_ge)
	);

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_THREAD_COUNT) ? {27'd0, tcount_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= 5'd1;
		end else if (psel && penable && pwrite && pready) begin
			tcount_q <= pwdata[4:0];
		end
	end

	assign n = eff_count(tcount_q);
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign id_ok = ({1'b0, id_q} < n);
	assign have = rdy_q || blk_q;
	assign status = (running_q && id_ok) ? rd : ST_STOPPED;

	// shared unit: reduce the start index, otherwise step an index with wrap
	always_comb begin
		if (state_q == S_MOD) begin
			u_a = t_q;
			u_inc = 1'b0;
		end else begin
			u_a = t_q;
			u_inc = 1'b1;
		end
	end

	always_comb begin
		mreq = '0;
		case (state_q)
			S_SWEEP: begin
				mreq.en = 1'b1;
				mreq.we = 1'b1;
				mreq.addr = t_q[IdxW-1:0];
				mreq.wdata = (t_q < n) ? ST_READY : ST_STOPPED;
			end
			S_SRD, S_WRD: begin
				mreq.en = 1'b1;
				mreq.addr = t_q[IdxW-1:0];
			end
			S_SEND: begin
				if (cmd_q == CMD_EXIT && have) begin
					mreq.en = 1'b1;
					mreq.we = 1'b1;
					mreq.addr = cur_q;
					mreq.wdata = ST_STOPPED;
				end
			end
			S_SETW: begin
				mreq.en = 1'b1;
				mreq.we = 1'b1;
				mreq.addr = id_q;
				mreq.wdata = sval_q;
			end
			S_WCHK: begin
				if (rd == req_q) begin
					mreq.en = 1'b1;
					mreq.we = 1'b1;
					mreq.addr = t_q[IdxW-1:0];
					mreq.wdata = ST_READY;
				end
			end
			S_STRD: begin
				mreq.en = 1'b1;
				mreq.addr = id_q;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			running_q <= 1'b0;
			cur_q <= '0;
			t_q <= '0;
			steps_q <= '0;
			rdy_q <= 1'b0;
			blk_q <= 1'b0;
			pick_q <= '0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			cand_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_STLAT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						done_q <= 1'b0;
						found_q <= 1'b0;
						cand_q <= '0;
						rdy_q <= 1'b0;
						blk_q <= 1'b0;
						state_q <= S_STRD;
						case (s_tuser)
							CMD_START: begin
								if (!running_q) begin
									t_q <= '0;
									state_q <= S_SWEEP;
								end
							end
							CMD_YIELD, CMD_PEEK, CMD_EXIT: begin
								if (running_q) begin
									if (n == CntW'(1)) begin
										state_q <= S_SEND;
									end else begin
										t_q <= {1'b0, cur_q} + CntW'(1);
										steps_q <= IdxW'(n - CntW'(1));
										state_q <= S_MOD;
									end
								end
							end
							CMD_SET: begin
								if (running_q && ({1'b0, s_tdata[3:0]} < n)) begin
									state_q <= S_SETW;
								end
							end
							CMD_WAKE: begin
								if (running_q && s_tdata[19:12] != ST_READY
										&& s_tdata[19:12] != ST_STOPPED) begin
									t_q <= '0;
									state_q <= S_WRD;
								end
							end
							CMD_YIELD_TO: begin
								if (running_q && ({1'b0, s_tdata[3:0]} < n)) begin
									cur_q <= s_tdata[3:0];
									done_q <= 1'b1;
								end
							end
							default: begin
								state_q <= S_STRD;
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (t_q[IdxW-1:0] == IdxW'(MaxThreads - 1)) begin
						running_q <= 1'b1;
						cur_q <= '0;
						state_q <= S_STRD;
					end else begin
						t_q <= t_q + CntW'(1);
					end
				end
				S_MOD: begin
					if (u_ge) begin
						t_q <= u_res;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (rd == ST_READY) begin
						rdy_q <= 1'b1;
						pick_q <= t_q[IdxW-1:0];
						state_q <= S_SEND;
					end else begin
						// remember the first blocked thread as a fallback
						if (!blk_q && rd != ST_STOPPED) begin
							blk_q <= 1'b1;
							pick_q <= t_q[IdxW-1:0];
						end
						if (steps_q == IdxW'(1)) begin
							state_q <= S_SEND;
						end else begin
							steps_q <= steps_q - IdxW'(1);
							t_q <= u_res;
							state_q <= S_SRD;
						end
					end
				end
				S_SEND: begin
					if (cmd_q == CMD_EXIT) begin
						if (have) begin
							cur_q <= pick_q;
						end else begin
							running_q <= 1'b0;
							cur_q <= '0;
						end
					end else if (have) begin
						cand_q <= pick_q;
						if (rdy_q || !only_q) begin
							found_q <= 1'b1;
							if (cmd_q == CMD_YIELD) begin
								cur_q <= pick_q;
								done_q <= 1'b1;
							end
						end
					end
					state_q <= S_STRD;
				end
				S_SETW: begin
					state_q <= S_STRD;
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (rd == req_q) begin
						done_q <= 1'b1;
					end
					if (u_ge) begin
						state_q <= S_STRD;
					end else begin
						t_q <= u_res;
						state_q <= S_WRD;
					end
				end
				S_STRD: begin
					state_q <= S_STLAT;
				end
				S_STLAT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item fields and result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tuser;
			id_q <= s_tdata[3:0];
			sval_q <= s_tdata[11:4];
			req_q <= s_tdata[19:12];
			only_q <= s_tdata[20];
		end
		if (state_q == S_STLAT && (!m_tvalid_q || m_tready)) begin
			out_q <= {status, cand_q, found_q, cur_q, running_q, done_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {5'd0, out_q};

	// inactive table reports no current thread, no change and a stopped entry
	a_inactive_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1]) |-> (m_tdata[5:2] == 4'd0 && m_tdata[0] == 1'b0
			&& m_tdata[18:11] == ST_STOPPED))
		else $error("inactive result carries thread data");

	a_found_needs_running: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6]) |-> m_tdata[1])
		else $error("candidate found while table inactive");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input ready right after an accepted item");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(mreq.en && mreq.we))
		else $error("table written while idle");

endmodule
